// ----- rtl/sorted_key_table_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key table
// Shared concurrent checks, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_UNIT_MACROS_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define SKT_ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("sorted key table check failed");

// Whenever the condition holds, the consequence holds in the next cycle.
`define SKT_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("sorted key table check failed");

`endif

// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, codes and shared types of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int DEPTH            = 64;
   localparam int KEY_BITS         = 20;
   localparam int IDX_BITS         = $clog2(DEPTH);
   localparam int COUNT_BITS       = $clog2(DEPTH + 1);
   localparam int OPCODE_BITS      = 2;
   localparam int LEVEL_BITS       = 2;
   localparam int RESULT_BITS      = 2;
   localparam int POS_BITS         = 6;
   localparam int ENTRY_COUNT_BITS = 7;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = 2'd2;
   localparam logic [LEVEL_BITS-1:0] STATUS_OPEN = 2'd0;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_INSERT,
      OP_LOOKUP,
      OP_UPDATE,
      OP_DELETE
   } opcode_type;

   typedef enum logic [RESULT_BITS-1:0] {
      RC_DONE,
      RC_NOT_FOUND,
      RC_DUPLICATE,
      RC_FULL
   } result_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE,
      CMD_UPDATE
   } cell_cmd_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [LEVEL_BITS-1:0] prio;
      logic [LEVEL_BITS-1:0] status;
   } entry_type;

   typedef struct packed {
      logic                sample;
      logic [KEY_BITS-1:0] sample_key;
      cell_cmd_type        cmd;
      entry_type           new_entry;
   } cell_ctrl_type;

   // Code 3 means nothing for a priority or a status; it counts as the top level.
   function automatic logic [LEVEL_BITS-1:0] sat_level(input logic [LEVEL_BITS-1:0] v);
      return (v > LEVEL_MAX) ? LEVEL_MAX : v;
   endfunction

endpackage

// ----- rtl/skt_if.sv -----
// ----------------------------------------------------------------------------
// Sorted key table channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface skt_req_if;
   logic                                valid;
   logic                                ready;
   logic [skt_pkg::OPCODE_BITS-1:0]     opcode;
   logic [skt_pkg::KEY_BITS-1:0]        key;
   logic [skt_pkg::LEVEL_BITS-1:0]      new_priority;
   logic [skt_pkg::LEVEL_BITS-1:0]      new_status;

   modport source (output valid, output opcode, output key, output new_priority,
                   output new_status, input ready);
   modport sink   (input valid, input opcode, input key, input new_priority,
                   input new_status, output ready);
endinterface

interface skt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [skt_pkg::RESULT_BITS-1:0]     result_code;
   logic [skt_pkg::POS_BITS-1:0]        position;
   logic [skt_pkg::LEVEL_BITS-1:0]      found_priority;
   logic [skt_pkg::LEVEL_BITS-1:0]      found_status;
   logic [skt_pkg::ENTRY_COUNT_BITS-1:0] entry_count;

   modport source (output valid, output result_code, output position,
                   output found_priority, output found_status, output entry_count,
                   input ready);
   modport sink   (input valid, input result_code, input position,
                   input found_priority, input found_status, input entry_count,
                   output ready);
endinterface

// ----- rtl/sorted_key_table_unit.sv -----
// An accepted request item is compared with all slots at acceptance; its response
// item is registered in the apply cycle, which waits while the response register
// is full. No new request item is taken until that apply cycle has been done.
// Reset: synchronous, active high; all slots become empty and the count is zero
// in the same cycle, with no clearing pass.
// ----------------------------------------------------------------------------
// Sorted key table unit
// A row of cells keeps unique keys in ascending order, with insert, lookup,
// update and delete, one request item and one response item at a time.
// ----------------------------------------------------------------------------
`include "sorted_key_table_unit_macros.svh"

module sorted_key_table_unit (
   input logic      clock,
   input logic      reset,
   skt_req_if.sink  req_bus,
   skt_rsp_if.source rsp_bus
);
   import skt_pkg::*;

   // The request is held here between the compare cycle and the apply cycle.
   state_type                 state_ff, state_in;
   opcode_type                op_ff;
   logic [KEY_BITS-1:0]       key_ff;
   logic [LEVEL_BITS-1:0]     prio_ff;
   logic [LEVEL_BITS-1:0]     status_ff;
   logic [COUNT_BITS-1:0]     count_ff, count_in;

   // Response register; it parts the table from the response side.
   logic                      rsp_valid_ff;
   result_type                rsp_code_ff, rsp_code_in;
   logic [POS_BITS-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [LEVEL_BITS-1:0]     rsp_prio_ff, rsp_prio_in;
   logic [LEVEL_BITS-1:0]     rsp_status_ff, rsp_status_in;

   logic                      accept;
   logic                      out_free;
   logic                      apply;
   logic                      req_ready;

   cell_ctrl_type             ctrl;
   cell_cmd_type              cmd;
   entry_type                 entries [DEPTH];
   logic [DEPTH-1:0]          less_vec;
   logic [DEPTH-1:0]          equal_vec;
   logic [DEPTH-1:0]          bound_vec;
   logic [DEPTH-1:0]          valid_vec;

   logic                      hit;
   logic                      full;
   logic [IDX_BITS-1:0]       hit_idx;
   logic [IDX_BITS-1:0]       bound_idx;
   entry_type                 hit_entry;

   assign accept   = req_bus.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Control: the compare cycle at acceptance, then the apply cycle, which waits
   // until the response register is free.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // No request item is taken while reset is held.
   always_comb begin
      req_ready = 1'b0;
      apply     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
         end
         ST_APPLY: begin
            apply = out_free;
         end
         default: begin
            req_ready = 1'b0;
            apply     = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request fields are latched at acceptance, with the levels saturated.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= opcode_type'(req_bus.opcode);
         key_ff    <= req_bus.key;
         prio_ff   <= sat_level(req_bus.new_priority);
         status_ff <= sat_level(req_bus.new_status);
      end
   end

   // The cell row. Cell 0 sees an always-less empty neighbor on its left, so an
   // insert at the front takes the new entry; the last cell pulls in an empty
   // slot from the right on a delete, which clears the vacated place.
   always_comb begin
      ctrl.sample               = accept;
      ctrl.sample_key           = req_bus.key;
      ctrl.cmd                  = apply ? cmd : CMD_HOLD;
      ctrl.new_entry.valid      = 1'b1;
      ctrl.new_entry.key        = key_ff;
      ctrl.new_entry.prio       = prio_ff;
      ctrl.new_entry.status     = (op_ff == OP_UPDATE) ? status_ff : STATUS_OPEN;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_less;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_less  = 1'b1;
      end else begin : g_inner_left
         assign left_entry = entries[i-1];
         assign left_less  = less_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_right
         assign right_entry = entries[i+1];
      end

      skt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_less   (left_less),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .less        (less_vec[i]),
         .equal       (equal_vec[i])
      );

      // Less flags form a run from slot 0, so the insert point is where it ends.
      assign bound_vec[i] = !less_vec[i] && left_less;
      assign valid_vec[i] = entries[i].valid;
   end

   // Both selection vectors are one-hot at most, so an OR of indexes encodes them.
   always_comb begin
      hit_idx   = '0;
      bound_idx = '0;
      hit_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (equal_vec[i]) begin
            hit_idx   = hit_idx | IDX_BITS'(i);
            hit_entry = hit_entry | entries[i];
         end
         if (bound_vec[i]) begin
            bound_idx = bound_idx | IDX_BITS'(i);
         end
      end
   end

   assign hit  = |equal_vec;
   assign full = (count_ff == COUNT_BITS'(DEPTH));

   // Operation decode for the apply cycle: what the cells do and what is reported.
   always_comb begin
      cmd           = CMD_HOLD;
      count_in      = count_ff;
      rsp_code_in   = RC_NOT_FOUND;
      rsp_pos_in    = '0;
      rsp_prio_in   = '0;
      rsp_status_in = '0;
      case (op_ff)
         OP_INSERT: begin
            if (hit) begin
               rsp_code_in   = RC_DUPLICATE;
               rsp_pos_in    = POS_BITS'(hit_idx);
               rsp_prio_in   = hit_entry.prio;
               rsp_status_in = hit_entry.status;
            end else if (full) begin
               rsp_code_in = RC_FULL;
            end else begin
               cmd           = CMD_INSERT;
               count_in      = count_ff + COUNT_BITS'(1);
               rsp_code_in   = RC_DONE;
               rsp_pos_in    = POS_BITS'(bound_idx);
               rsp_prio_in   = prio_ff;
               rsp_status_in = STATUS_OPEN;
            end
         end
         OP_LOOKUP: begin
            if (hit) begin
               rsp_code_in   = RC_DONE;
               rsp_pos_in    = POS_BITS'(hit_idx);
               rsp_prio_in   = hit_entry.prio;
               rsp_status_in = hit_entry.status;
            end
         end
         OP_UPDATE: begin
            if (hit) begin
               cmd           = CMD_UPDATE;
               rsp_code_in   = RC_DONE;
               rsp_pos_in    = POS_BITS'(hit_idx);
               rsp_prio_in   = prio_ff;
               rsp_status_in = status_ff;
            end
         end
         OP_DELETE: begin
            if (hit) begin
               cmd           = CMD_DELETE;
               count_in      = count_ff - COUNT_BITS'(1);
               rsp_code_in   = RC_DONE;
               rsp_pos_in    = POS_BITS'(hit_idx);
               rsp_prio_in   = hit_entry.prio;
               rsp_status_in = hit_entry.status;
            end
         end
         default: begin
            cmd = CMD_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (apply) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (apply) begin
         rsp_code_ff   <= rsp_code_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_code    = rsp_code_ff;
   assign rsp_bus.position       = rsp_pos_ff;
   assign rsp_bus.found_priority = rsp_prio_ff;
   assign rsp_bus.found_status   = rsp_status_ff;
   assign rsp_bus.entry_count    = ENTRY_COUNT_BITS'(count_ff);

   // Keys are unique, so at most one slot can match the searched key.
   `SKT_ASSERT_IMPLY(a_single_match, clock, reset, state_ff == ST_APPLY, $onehot0(equal_vec))
   // The occupied slots are exactly as many as the count says.
   `SKT_ASSERT_IMPLY(a_count_matches, clock, reset, 1'b1, $countones(valid_vec) == count_ff)
   // A successful insert grows the table by exactly one entry.
   `SKT_ASSERT_NEXT(a_insert_grows, clock, reset, apply && cmd == CMD_INSERT, count_ff == $past(count_ff) + COUNT_BITS'(1))

endmodule

// ----- rtl/skt_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted key table cell
// One table slot: compares against the broadcast key and shifts with neighbors.
// ----------------------------------------------------------------------------
module skt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  skt_pkg::cell_ctrl_type ctrl,
   input  skt_pkg::entry_type     left_entry,
   input  logic                   left_less,
   input  skt_pkg::entry_type     right_entry,
   output skt_pkg::entry_type     entry,
   output logic                   less,
   output logic                   equal
);
   import skt_pkg::*;

   entry_type entry_ff, entry_in;
   logic      less_ff, less_in;
   logic      equal_ff, equal_in;

   always_comb begin
      less_in  = less_ff;
      equal_in = equal_ff;
      if (ctrl.sample) begin
         less_in  = entry_ff.valid && (entry_ff.key < ctrl.sample_key);
         equal_in = entry_ff.valid && (entry_ff.key == ctrl.sample_key);
      end
   end

   // Slots below the search point stay; the rest shift up on insert, down on delete.
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.cmd)
         CMD_INSERT: begin
            if (!less_ff) begin
               entry_in = left_less ? ctrl.new_entry : left_entry;
            end
         end
         CMD_DELETE: begin
            if (!less_ff) begin
               entry_in = right_entry;
            end
         end
         CMD_UPDATE: begin
            if (equal_ff) begin
               entry_in.prio   = ctrl.new_entry.prio;
               entry_in.status = ctrl.new_entry.status;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         less_ff  <= 1'b0;
         equal_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         less_ff  <= less_in;
         equal_ff <= equal_in;
      end
   end

   assign entry = entry_ff;
   assign less  = less_ff;
   assign equal = equal_ff;

endmodule

// ----- bench/tb_sorted_key_table_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted key table unit testbench
// Drives insert, lookup, update and delete request items through the request
// channel and checks every response item against a behavioral table kept in
// the bench. Directed corner items come first, then random phases that fill,
// drain and churn the table under bursty traffic and response back-pressure.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_unit;
   import skt_pkg::*;

   // One request item as the bench sees it.
   typedef struct packed {
      opcode_type            opcode;
      logic [KEY_BITS-1:0]   key;
      logic [LEVEL_BITS-1:0] new_priority;
      logic [LEVEL_BITS-1:0] new_status;
   } table_req_type;

   // One response item, field for field as the response channel carries it.
   typedef struct packed {
      result_type                  result_code;
      logic [POS_BITS-1:0]         position;
      logic [LEVEL_BITS-1:0]       found_priority;
      logic [LEVEL_BITS-1:0]       found_status;
      logic [ENTRY_COUNT_BITS-1:0] entry_count;
   } table_rsp_type;

   localparam int RANDOM_ITEMS = 1550;
   localparam int POOL_SIZE    = 128;
   localparam int HOLD_START   = 1500;   // receiver cycle at which the long hold-off begins
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   skt_req_if req_bus ();
   skt_rsp_if rsp_bus ();

   sorted_key_table_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Every input of the block is known from time zero on.
   initial begin
      req_bus.valid        = 1'b0;
      req_bus.opcode       = '0;
      req_bus.key          = '0;
      req_bus.new_priority = '0;
      req_bus.new_status   = '0;
      rsp_bus.ready        = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Behavioral table. It mirrors the sorted store of the block and is
   // advanced once per accepted request item.
   // ------------------------------------------------------------------------
   logic [KEY_BITS-1:0]   table_key    [DEPTH];
   logic [LEVEL_BITS-1:0] table_prio   [DEPTH];
   logic [LEVEL_BITS-1:0] table_status [DEPTH];
   int                    table_count = 0;

   // A level code of 3 has no meaning and is taken as the top level.
   function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] v);
      return (v == 2'd3) ? LEVEL_MAX : v;
   endfunction

   // Applies one request item to the behavioral table and returns the
   // response item that the block must give for it.
   function automatic table_rsp_type apply_table_op(input table_req_type r);
      table_rsp_type         o;
      int                    pos;
      bit                    hit;
      logic [LEVEL_BITS-1:0] pri;
      logic [LEVEL_BITS-1:0] st;
      o   = '0;
      pri = clamp_level(r.new_priority);
      st  = clamp_level(r.new_status);
      // Lower bound: the first valid slot whose key is not below the request key.
      pos = 0;
      while (pos < table_count && table_key[pos] < r.key)
         pos++;
      hit = (pos < table_count) && (table_key[pos] == r.key);

      if (r.opcode == OP_INSERT) begin
         if (hit) begin
            // A duplicate reports the existing entry and leaves it alone.
            o.result_code    = RC_DUPLICATE;
            o.position       = POS_BITS'(pos);
            o.found_priority = table_prio[pos];
            o.found_status   = table_status[pos];
         end else if (table_count >= DEPTH) begin
            o.result_code = RC_FULL;
         end else begin
            for (int i = table_count; i > pos; i--) begin
               table_key[i]    = table_key[i-1];
               table_prio[i]   = table_prio[i-1];
               table_status[i] = table_status[i-1];
            end
            table_key[pos]    = r.key;
            table_prio[pos]   = pri;
            table_status[pos] = STATUS_OPEN;
            table_count++;
            o.result_code    = RC_DONE;
            o.position       = POS_BITS'(pos);
            o.found_priority = pri;
            o.found_status   = STATUS_OPEN;
         end
      end else if (!hit) begin
         o.result_code = RC_NOT_FOUND;
      end else begin
         o.result_code = RC_DONE;
         o.position    = POS_BITS'(pos);
         case (r.opcode)
            OP_LOOKUP: begin
               o.found_priority = table_prio[pos];
               o.found_status   = table_status[pos];
            end
            OP_UPDATE: begin
               table_prio[pos]   = pri;
               table_status[pos] = st;
               o.found_priority  = pri;
               o.found_status    = st;
            end
            default: begin
               // Delete reports the removed entry, closes the gap and clears
               // the slot that falls empty at the top.
               o.found_priority = table_prio[pos];
               o.found_status   = table_status[pos];
               for (int i = pos; i + 1 < table_count; i++) begin
                  table_key[i]    = table_key[i+1];
                  table_prio[i]   = table_prio[i+1];
                  table_status[i] = table_status[i+1];
               end
               table_count--;
               table_key[table_count]    = '0;
               table_prio[table_count]   = '0;
               table_status[table_count] = '0;
            end
         endcase
      end
      o.entry_count = ENTRY_COUNT_BITS'(table_count);
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction.
   // ------------------------------------------------------------------------
   table_req_type       request_backlog [$];
   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

   function automatic void queue_request(input opcode_type op, input int unsigned k,
                                         input int unsigned pri, input int unsigned st);
      table_req_type r;
      r.opcode       = op;
      r.key          = KEY_BITS'(k);
      r.new_priority = LEVEL_BITS'(pri);
      r.new_status   = LEVEL_BITS'(st);
      request_backlog = {request_backlog, r};
   endfunction

   // Draws one random request item. Keys mostly come from the first part of
   // the pool so that lookups, updates, deletes and duplicates hit; one item in
   // ten takes a fresh random key that almost always misses.
   function automatic void queue_random_request(input int pool_used, input int insert_pct,
                                                input int delete_pct);
      int          roll;
      int unsigned k;
      opcode_type  op;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct)
         op = OP_INSERT;
      else if (roll < insert_pct + delete_pct)
         op = OP_DELETE;
      else if ($urandom_range(0, 1) == 0)
         op = OP_LOOKUP;
      else
         op = OP_UPDATE;
      if ($urandom_range(0, 9) == 0)
         k = $urandom;
      else
         k = key_pool[$urandom_range(0, pool_used - 1)];
      queue_request(op, k, $urandom_range(0, 3), $urandom_range(0, 3));
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. It offers items in bursts of random length separated by
   // random gaps. An offered item stays on the bus until it is taken, and the
   // next one follows on the very next edge when there is no gap.
   // ------------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin : request_driver
      table_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 0;
         gap_left      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left      <= gap_left - 1;
         end else if (request_backlog.size() > 0) begin
            nxt = request_backlog.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.opcode       <= nxt.opcode;
            req_bus.key          <= nxt.key;
            req_bus.new_priority <= nxt.new_priority;
            req_bus.new_status   <= nxt.new_status;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response receiver. It switches between a few stall patterns at random
   // intervals, and once, at a fixed cycle of its own count, holds ready low
   // for a long stretch so that the block backs up and stalls its input.
   // ------------------------------------------------------------------------
   int ready_cycle;
   int hold_left;
   int stall_mode;
   int mode_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_cycle   <= 0;
         hold_left     <= 0;
         stall_mode    <= 0;
         mode_left     <= 0;
      end else begin
         ready_cycle <= ready_cycle + 1;
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end

         if (ready_cycle == HOLD_START) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
         end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
         end else begin
            case (stall_mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 9) < 7);
               2:       rsp_bus.ready <= (ready_cycle % 4 != 3);
               default: rsp_bus.ready <= (ready_cycle % 7 == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. On every accepted request item the behavioral table computes the
   // response to come; on every accepted response item the oldest outstanding
   // response is compared with it, field by field.
   // ------------------------------------------------------------------------
   table_rsp_type pending_outcomes [$];
   int            mismatch_count = 0;

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : response_monitor
      table_req_type req_seen;
      table_rsp_type outcome;
      table_rsp_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            table_key[i]    = '0;
            table_prio[i]   = '0;
            table_status[i] = '0;
         end
         table_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            req_seen.opcode       = opcode_type'(req_bus.opcode);
            req_seen.key          = req_bus.key;
            req_seen.new_priority = req_bus.new_priority;
            req_seen.new_status   = req_bus.new_status;
            outcome = apply_table_op(req_seen);
            pending_outcomes = {pending_outcomes, outcome};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: response item with none expected, expected none, actual code %0d",
                        $time, rsp_bus.result_code);
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               compare_field("result_code", 8'(want.result_code), 8'(rsp_bus.result_code));
               compare_field("position", 8'(want.position), 8'(rsp_bus.position));
               compare_field("found_priority", 8'(want.found_priority),
                             8'(rsp_bus.found_priority));
               compare_field("found_status", 8'(want.found_status), 8'(rsp_bus.found_status));
               compare_field("entry_count", 8'(want.entry_count), 8'(rsp_bus.entry_count));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      int made;
      int seg;
      int seg_len;
      int phase;
      int pool_used;
      int insert_pct;
      int delete_pct;

      // The pool holds both key extremes and random keys in between.
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = KEY_BITS'($urandom);

      // Directed items. An empty table must miss key zero even though its
      // cleared slots hold zero keys.
      queue_request(OP_LOOKUP, 0, 0, 0);
      queue_request(OP_DELETE, 0, 0, 0);
      queue_request(OP_UPDATE, 20'hFFFFF, 1, 1);
      // Inserts at the middle, the bottom and the top; priority 3 saturates.
      queue_request(OP_INSERT, 20'h12345, 3, 0);
      queue_request(OP_INSERT, 0, 0, 2);
      queue_request(OP_INSERT, 20'hFFFFF, 2, 1);
      // A duplicate insert reports the stored entry untouched.
      queue_request(OP_INSERT, 20'h12345, 0, 0);
      queue_request(OP_INSERT, 20'h80000, 1, 0);
      queue_request(OP_LOOKUP, 0, 0, 0);
      queue_request(OP_LOOKUP, 20'hFFFFF, 0, 0);
      queue_request(OP_LOOKUP, 20'h55555, 0, 0);
      // Updates, with code 3 saturating in both level fields.
      queue_request(OP_UPDATE, 20'h12345, 1, 3);
      queue_request(OP_UPDATE, 0, 3, 1);
      queue_request(OP_UPDATE, 20'hFFFFF, 0, 2);
      queue_request(OP_LOOKUP, 20'h12345, 0, 0);
      queue_request(OP_INSERT, 0, 2, 2);
      // Deletes from the middle, the bottom and the top, then a miss.
      queue_request(OP_DELETE, 20'h80000, 0, 0);
      queue_request(OP_DELETE, 0, 0, 0);
      queue_request(OP_DELETE, 20'hFFFFF, 0, 0);
      queue_request(OP_DELETE, 20'hFFFFF, 0, 0);
      queue_request(OP_LOOKUP, 0, 0, 0);
      queue_request(OP_DELETE, 20'h12345, 0, 0);
      // Insert ignores the status field and always stores open.
      queue_request(OP_INSERT, 20'hAAAAA, 2, 3);
      queue_request(OP_LOOKUP, 20'hAAAAA, 0, 0);
      queue_request(OP_DELETE, 20'hAAAAA, 0, 0);

      // Random phases. The first one fills the table well past full and the
      // second drains it; later phases pick a mix at random. The last phase
      // is cut short so that the random items add up to the planned total.
      made = 0;
      seg  = 0;
      while (made < RANDOM_ITEMS) begin
         seg_len = $urandom_range(80, 200);
         if (seg_len > RANDOM_ITEMS - made)
            seg_len = RANDOM_ITEMS - made;
         phase   = (seg < 2) ? seg : $urandom_range(0, 3);
         case (phase)
            0:       begin pool_used = POOL_SIZE; insert_pct = 70; delete_pct = 5;  end
            1:       begin pool_used = POOL_SIZE; insert_pct = 10; delete_pct = 60; end
            2:       begin pool_used = 8;         insert_pct = 30; delete_pct = 25; end
            default: begin pool_used = 64;        insert_pct = 35; delete_pct = 30; end
         endcase
         for (int i = 0; i < seg_len; i++)
            queue_random_request(pool_used, insert_pct, delete_pct);
         made += seg_len;
         seg++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Sample at the falling edge so that every update of the rising edge
      // has settled.
      @(negedge clock);
      while (request_backlog.size() != 0 || req_bus.valid || pending_outcomes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_if.sv
rtl/skt_cell.sv
rtl/sorted_key_table_unit.sv
bench/tb_sorted_key_table_unit.sv
